// ===== hdl/psw_pkg.sv =====
// Package for the priority schedule block: payload types, field widths,
// microcode step names, control/status structs and the microcode ROM.
// Depends on nothing; every other file of the block but psw_ram uses it.
package psw_pkg;

  // Field widths
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned ID_W      = 7;
  localparam int unsigned WAIT_W    = 22;
  localparam int unsigned WSUM_W    = 27;
  localparam int unsigned TSUM_W    = 28;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // Default job capacity
  localparam int unsigned MAX_JOBS_DEF = 64;

  // Register index bit of the APB address
  localparam int unsigned REG_SEL_BIT = 2;

  // Input beat: one job
  typedef struct packed {
    logic [BURST_W-1:0]        burst;
    logic signed [PRIO_W-1:0]  prio;
    logic                      final_job;
  } job_t;

  // Output beat: one scheduled job
  typedef struct packed {
    logic [ID_W-1:0]           job_id;
    logic [BURST_W-1:0]        job_burst;
    logic signed [PRIO_W-1:0]  job_prio;
    logic [WAIT_W-1:0]         wait_time;
    logic [WAIT_W-1:0]         turnaround;
    logic [WSUM_W-1:0]         wait_total;
    logic [TSUM_W-1:0]         turnaround_total;
    logic                      overflowed;
    logic                      end_of_run;
  } res_t;

  // Microcode step addresses
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_SORT_INIT = 4'd1;
  localparam step_t STEP_PASS      = 4'd2;
  localparam step_t STEP_LOAD_I    = 4'd3;
  localparam step_t STEP_SCAN      = 4'd4;
  localparam step_t STEP_SWAP_A    = 4'd5;
  localparam step_t STEP_SWAP_B    = 4'd6;
  localparam step_t STEP_EMIT_INIT = 4'd7;
  localparam step_t STEP_EMIT      = 4'd8;
  localparam step_t STEP_HOLD      = 4'd9;
  localparam step_t STEP_NEXT      = 4'd10;
  localparam step_t STEP_FINISH    = 4'd11;

  // Read address source
  typedef enum logic [2:0] {
    RD_I    = 3'd0,
    RD_J    = 3'd1,
    RD_JN   = 3'd2,
    RD_K    = 3'd3,
    RD_ZERO = 3'd4
  } rsel_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE   = 3'd0,
    C_ALWAYS = 3'd1,
    C_IDLE   = 3'd2,
    C_FEW    = 3'd3,
    C_SCAN   = 3'd4,
    C_PASS   = 3'd5,
    C_BUSY   = 3'd6,
    C_MORE   = 3'd7
  } cond_e;

  // Control word: one per microcode step
  typedef struct packed {
    logic   in_rdy;     // take job beats and store them
    rsel_e  rd_sel;     // memory read address
    logic   clr_i;      // restart the outer pass counter
    logic   set_scan;   // j = i + 1, best = i
    logic   cap_i;      // capture entry i as current and best
    logic   scan;       // compare entry j against best, advance j
    logic   wr_best;    // write best entry to slot i
    logic   wr_swap;    // write old entry i to best slot, advance i
    logic   emit_init;  // clear emit counter and sums
    logic   emit_calc;  // fill the output register from entry k
    logic   finish;     // clear job count and drop flag
    cond_e  cond;
    step_t  target;
  } ctrl_t;

  // Status from the datapath for the jump conditions
  typedef struct packed {
    logic start;
    logic few;
    logic scan_more;
    logic pass_more;
    logic out_busy;
    logic emit_more;
  } stat_t;

  // Microcode ROM
  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    w = '0;
    w.rd_sel = RD_I;
    w.cond   = C_NONE;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_IDLE;
        w.target = STEP_IDLE;
      end
      STEP_SORT_INIT: begin
        w.clr_i  = 1'b1;
        w.cond   = C_FEW;
        w.target = STEP_EMIT_INIT;
      end
      STEP_PASS: begin
        w.rd_sel   = RD_I;
        w.set_scan = 1'b1;
      end
      STEP_LOAD_I: begin
        w.rd_sel = RD_J;
        w.cap_i  = 1'b1;
      end
      STEP_SCAN: begin
        w.rd_sel = RD_JN;
        w.scan   = 1'b1;
        w.cond   = C_SCAN;
        w.target = STEP_SCAN;
      end
      STEP_SWAP_A: begin
        w.wr_best = 1'b1;
      end
      STEP_SWAP_B: begin
        w.wr_swap = 1'b1;
        w.cond    = C_PASS;
        w.target  = STEP_PASS;
      end
      STEP_EMIT_INIT: begin
        w.rd_sel    = RD_ZERO;
        w.emit_init = 1'b1;
      end
      STEP_EMIT: begin
        w.rd_sel    = RD_K;
        w.emit_calc = 1'b1;
      end
      STEP_HOLD: begin
        w.rd_sel = RD_K;
        w.cond   = C_BUSY;
        w.target = STEP_HOLD;
      end
      STEP_NEXT: begin
        w.rd_sel = RD_K;
        w.cond   = C_MORE;
        w.target = STEP_EMIT;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/psw_job_if.sv =====
// Job channel: valid/ready handshake carrying one job per beat.
// Depends on psw_pkg for the payload type.
interface psw_job_if;
  logic          valid;
  logic          ready;
  psw_pkg::job_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/psw_res_if.sv =====
// Result channel: valid/ready handshake carrying one scheduled job per beat.
// Depends on psw_pkg for the payload type.
interface psw_res_if;
  logic          valid;
  logic          ready;
  psw_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/psw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module psw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/psw_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on psw_pkg for the control word, status struct and ROM.
module psw_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psw_pkg::stat_t  stat_i,
  output psw_pkg::ctrl_t  ctrl_o
);
  import psw_pkg::*;

  step_t upc_q, upc_d;
  ctrl_t ctrl;
  logic  jump;

  // Look up the current control word
  assign ctrl   = ucode(upc_q);
  assign ctrl_o = ctrl;

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_NONE:   jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_IDLE:   jump = !stat_i.start;
      C_FEW:    jump = stat_i.few;
      C_SCAN:   jump = stat_i.scan_more;
      C_PASS:   jump = stat_i.pass_more;
      C_BUSY:   jump = stat_i.out_busy;
      C_MORE:   jump = stat_i.emit_more;
      default:  jump = 1'b1;
    endcase
    upc_d = jump ? ctrl.target : step_t'(upc_q + step_t'(1));
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== hdl/psw_datapath.sv =====
// Datapath: job memory, sort index and best registers, emit sums and the
// output register. Driven by the control word of psw_useq.
// Depends on psw_pkg, psw_job_if, psw_res_if and psw_ram.
module psw_datapath #(
  parameter int unsigned MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            lvf_i,
  input  psw_pkg::ctrl_t  ctrl_i,
  output psw_pkg::stat_t  stat_o,
  psw_job_if.sink         job_i,
  psw_res_if.source       res_o
);
  import psw_pkg::*;

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned WORD_W = IDX_W + PRIO_W + BURST_W;
  localparam int unsigned SUM_W = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;
  localparam int unsigned PRIO_LO = BURST_W;
  localparam int unsigned ID_LO = BURST_W + PRIO_W;

  // Control registers
  logic [CNT_W-1:0] count_q;
  logic             drop_q;
  logic [CNT_W-1:0] i_q, j_q, k_q;
  logic [IDX_W-1:0] best_q;
  logic             out_valid_q;

  // Payload registers
  logic [WORD_W-1:0] word_i_q;
  logic [WORD_W-1:0] best_word_q;
  logic [TSUM_W-1:0] wait_q;
  logic [WSUM_W-1:0] wsum_q;
  logic [TSUM_W-1:0] tsum_q;
  res_t              res_q;

  // Memory ports
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  logic                     accept, full, load_we, better, last, res_take;
  logic [CNT_W-1:0]         jn;
  logic signed [PRIO_W-1:0] rd_prio, best_prio;
  logic [BURST_W-1:0]       rd_burst;
  logic [SUM_W-1:0]         id_plus;
  logic [TSUM_W-1:0]        turn;
  logic [WSUM_W-1:0]        wsum_n;
  logic [TSUM_W-1:0]        tsum_n;

  assign job_i.ready = ctrl_i.in_rdy;
  assign accept      = job_i.valid && ctrl_i.in_rdy;
  assign full        = (count_q == CNT_W'(MAX_JOBS));
  assign load_we     = accept && !full;
  assign res_take    = out_valid_q && res_o.ready;
  assign jn          = CNT_W'(j_q + CNT_W'(1));

  assign rd_burst  = rdata[BURST_W-1:0];
  assign rd_prio   = signed'(rdata[PRIO_LO +: PRIO_W]);
  assign best_prio = signed'(best_word_q[PRIO_LO +: PRIO_W]);
  assign better    = lvf_i ? (rd_prio < best_prio) : (rd_prio > best_prio);

  // Emit arithmetic, kept wide enough for the largest totals
  assign id_plus = SUM_W'(rdata[ID_LO +: IDX_W]) + SUM_W'(1);
  assign turn    = wait_q + TSUM_W'(rd_burst);
  assign wsum_n  = wsum_q + wait_q[WSUM_W-1:0];
  assign tsum_n  = tsum_q + turn;
  assign last    = ({1'b0, k_q} + (CNT_W + 1)'(1)) == {1'b0, count_q};

  // Status for the sequencer
  assign stat_o.start     = accept && job_i.data.final_job;
  assign stat_o.few       = count_q < CNT_W'(2);
  assign stat_o.scan_more = ({1'b0, j_q} + (CNT_W + 1)'(1)) < {1'b0, count_q};
  assign stat_o.pass_more = ({1'b0, i_q} + (CNT_W + 1)'(2)) < {1'b0, count_q};
  assign stat_o.out_busy  = out_valid_q && !res_o.ready;
  assign stat_o.emit_more = k_q < count_q;

  // Select the write port source
  always_comb begin
    we    = 1'b0;
    waddr = count_q[IDX_W-1:0];
    wdata = {count_q[IDX_W-1:0], job_i.data.prio, job_i.data.burst};
    if (load_we) begin
      we = 1'b1;
    end else if (ctrl_i.wr_best) begin
      we    = 1'b1;
      waddr = i_q[IDX_W-1:0];
      wdata = best_word_q;
    end else if (ctrl_i.wr_swap) begin
      we    = 1'b1;
      waddr = best_q;
      wdata = word_i_q;
    end
  end

  // Select the read address
  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_I:    raddr = i_q[IDX_W-1:0];
      RD_J:    raddr = j_q[IDX_W-1:0];
      RD_JN:   raddr = jn[IDX_W-1:0];
      RD_K:    raddr = k_q[IDX_W-1:0];
      RD_ZERO: raddr = '0;
      default: raddr = '0;
    endcase
  end

  psw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_JOBS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Track job count, drop flag and sort/emit indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_we) begin
        count_q <= CNT_W'(count_q + CNT_W'(1));
      end
      if (accept && full) begin
        drop_q <= 1'b1;
      end
      if (ctrl_i.finish) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end
      if (ctrl_i.clr_i) begin
        i_q <= '0;
      end
      if (ctrl_i.wr_swap) begin
        i_q <= CNT_W'(i_q + CNT_W'(1));
      end
      if (ctrl_i.set_scan) begin
        j_q    <= CNT_W'(i_q + CNT_W'(1));
        best_q <= i_q[IDX_W-1:0];
      end
      if (ctrl_i.scan) begin
        j_q <= jn;
        if (better) begin
          best_q <= j_q[IDX_W-1:0];
        end
      end
      if (ctrl_i.emit_init) begin
        k_q <= '0;
      end
      if (ctrl_i.emit_calc) begin
        k_q <= CNT_W'(k_q + CNT_W'(1));
      end
      if (ctrl_i.emit_calc) begin
        out_valid_q <= 1'b1;
      end else if (res_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture entries and build results
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_i) begin
      word_i_q    <= rdata;
      best_word_q <= rdata;
    end
    if (ctrl_i.scan && better) begin
      best_word_q <= rdata;
    end
    if (ctrl_i.emit_init) begin
      wait_q <= '0;
      wsum_q <= '0;
      tsum_q <= '0;
    end
    if (ctrl_i.emit_calc) begin
      wait_q                 <= turn;
      wsum_q                 <= wsum_n;
      tsum_q                 <= tsum_n;
      res_q.job_id           <= id_plus[ID_W-1:0];
      res_q.job_burst        <= rd_burst;
      res_q.job_prio         <= rd_prio;
      res_q.wait_time        <= wait_q[WAIT_W-1:0];
      res_q.turnaround       <= turn[WAIT_W-1:0];
      res_q.wait_total       <= last ? wsum_n : '0;
      res_q.turnaround_total <= last ? tsum_n : '0;
      res_q.overflowed       <= drop_q;
      res_q.end_of_run       <= last;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

`ifndef SYNTHESIS
  // No job is taken while a result is still pending
  a_no_load_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.in_rdy && out_valid_q))
    else $error("job channel open while a result is pending");

  // The job count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_JOBS))
    else $error("job count above capacity");

  // The scan pointer stays inside the stored set
  a_scan_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.scan |-> (j_q < count_q))
    else $error("scan pointer beyond stored jobs");

  // A new result is only built once the previous one has left
  a_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_calc |-> !out_valid_q)
    else $error("result overwritten before it was taken");

  // Finishing a run empties the set
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish |=> (count_q == '0) && !drop_q)
    else $error("set not cleared after a run");
`endif

endmodule

// ===== hdl/priority_schedule_wait_times.sv =====
// Non-preemptive priority scheduler.
// Jobs arrive on job_i, one per beat, each with a burst and a signed
// priority; the beat with final_job set closes the set. Job ids are the
// arrival position plus one. Jobs beyond MAX_JOBS are dropped and every
// result of that set reports overflowed.
// Jobs are loaded one per cycle while the block is idle. After the final
// job the set is ordered by selection sort in one memory, paced by the
// single read port that the scan steps through one entry a cycle.
// Results then leave on res_o in schedule order, each built only once the
// previous one has been taken, with wait and turnaround times; the
// last beat carries end_of_run and the totals. A stalled receiver holds the
// result register and the microcode waits. No new job is taken until the
// whole schedule has been delivered.
// Reset clears the job count, drop flag, sequencer and output valid; the
// job memory needs no clearing pass. lower_value_first sits at APB address
// 0 and may be written only while the block is idle.
// Depends on psw_pkg, the channel interfaces, psw_useq and psw_datapath.
module priority_schedule_wait_times #(
  parameter int unsigned MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psw_pkg::APB_AW-1:0]  paddr,
  input  logic [psw_pkg::APB_DW-1:0]  pwdata,
  output logic [psw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  psw_job_if.sink                     job_i,
  psw_res_if.source                   res_o
);
  import psw_pkg::*;

  logic  lvf_q;
  logic  reg_sel;
  ctrl_t ctrl;
  stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = !paddr[REG_SEL_BIT];

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvf_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      lvf_q <= pwdata[0];
    end
  end

  // Return register contents
  assign prdata = reg_sel ? {{(APB_DW - 1){1'b0}}, lvf_q} : '0;

  psw_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  psw_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lvf_i  (lvf_q),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .job_i  (job_i),
    .res_o  (res_o)
  );

endmodule

// ===== test/priority_schedule_wait_times_test.sv =====
// Self-checking bench for priority_schedule_wait_times: a directed table, then random job sets.
// A scheduler model in the bench predicts every result beat, and the APB register is read back.
// Depends on psw_pkg, psw_job_if, psw_res_if and the scheduler RTL.
module priority_schedule_wait_times_test;
  import psw_pkg::*;

  localparam int JOB_CAP       = MAX_JOBS_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;

  localparam logic [APB_AW-1:0] ADDR_LOWER_FIRST = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_SPARE       = 3'd4;
  localparam logic [APB_DW-1:0] MODE_HIGH_FIRST  = 32'd0;
  localparam logic [APB_DW-1:0] MODE_LOW_FIRST   = 32'd1;

  // Register action taken before a table row
  typedef enum logic [1:0] {
    CFG_KEEP,
    CFG_HIGH_FIRST,
    CFG_LOW_FIRST,
    CFG_POKE_SPARE
  } cfg_e;

  typedef struct packed {
    cfg_e  cfg;
    job_t  beat;
    logic  typed;
    res_t  want;
  } row_t;

  // Directed jobs; typed rows are one-job sets whose result is plain to see
  localparam row_t PLAN [23] = '{
    '{CFG_HIGH_FIRST, '{16'd65535, 16'sh8000, 1'b1}, 1'b1,
      '{7'd1, 16'd65535, 16'sh8000, 22'd0, 22'd65535, 27'd0, 28'd65535, 1'b0, 1'b1}},
    '{CFG_KEEP, '{16'd0, 16'sh7fff, 1'b1}, 1'b1,
      '{7'd1, 16'd0, 16'sh7fff, 22'd0, 22'd0, 27'd0, 28'd0, 1'b0, 1'b1}},
    '{CFG_KEEP, '{16'd10, 16'sh0005, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd20, 16'shfffd, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd30, 16'sh0005, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd40, 16'sh7fff, 1'b1}, 1'b0, '0},
    '{CFG_KEEP, '{16'd1, 16'sh0000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd2, 16'sh0000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd3, 16'sh0000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd65535, 16'sh0000, 1'b1}, 1'b0, '0},
    '{CFG_LOW_FIRST, '{16'd100, 16'shffff, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd200, 16'sh8000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd300, 16'sh8000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd400, 16'sh7fff, 1'b1}, 1'b0, '0},
    '{CFG_POKE_SPARE, '{16'd7, 16'sh0001, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd8, 16'shffff, 1'b1}, 1'b0, '0},
    '{CFG_KEEP, '{16'd65535, 16'sh7fff, 1'b1}, 1'b1,
      '{7'd1, 16'd65535, 16'sh7fff, 22'd0, 22'd65535, 27'd0, 28'd65535, 1'b0, 1'b1}},
    '{CFG_KEEP, '{16'd65535, 16'sh8000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd65535, 16'sh7fff, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd65535, 16'shffff, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd65535, 16'sh0000, 1'b1}, 1'b0, '0},
    '{CFG_HIGH_FIRST, '{16'd0, 16'sh8000, 1'b0}, 1'b0, '0},
    '{CFG_KEEP, '{16'd0, 16'sh8000, 1'b1}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  psw_job_if job_if ();
  psw_res_if res_if ();

  priority_schedule_wait_times dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .job_i   (job_if),
    .res_o   (res_if)
  );

  // Scheduler model state
  logic [BURST_W-1:0]       held_burst [JOB_CAP];
  logic signed [PRIO_W-1:0] held_prio  [JOB_CAP];
  int                       held_id    [JOB_CAP];
  int                       held_n     = 0;
  bit                       held_drop  = 1'b0;
  bit                       low_first  = 1'b0;
  res_t                     sched_q [$];

  int   mismatches  = 0;
  int   cycle_count = 0;
  int   src_idle    = 0;
  int   sink_idle   = 0;
  res_t want_beat;

  always #6 clk_i = ~clk_i;

  // Store one accepted job; on the final job order the set and queue its schedule
  function automatic void take_job(job_t beat);
    int                       best;
    logic [BURST_W-1:0]       tb;
    logic signed [PRIO_W-1:0] tp;
    int                       ti;
    bit                       better;
    longint unsigned          waited;
    longint unsigned          turn;
    longint unsigned          wsum;
    longint unsigned          tsum;
    res_t                     r;
    if (held_n < JOB_CAP) begin
      held_burst[held_n] = beat.burst;
      held_prio[held_n]  = beat.prio;
      held_id[held_n]    = held_n;
      held_n++;
    end else begin
      held_drop = 1'b1;
    end
    if (!beat.final_job) return;
    // Selection sort with swaps; only a strictly better priority moves the pick
    for (int i = 0; i + 1 < held_n; i++) begin
      best = i;
      for (int k = i + 1; k < held_n; k++) begin
        better = low_first ? (held_prio[k] < held_prio[best])
                           : (held_prio[k] > held_prio[best]);
        if (better) best = k;
      end
      if (best != i) begin
        tb = held_burst[i];
        tp = held_prio[i];
        ti = held_id[i];
        held_burst[i] = held_burst[best];
        held_prio[i]  = held_prio[best];
        held_id[i]    = held_id[best];
        held_burst[best] = tb;
        held_prio[best]  = tp;
        held_id[best]    = ti;
      end
    end
    // Walk the schedule, accumulating wait and turnaround
    waited = 0;
    wsum   = 0;
    tsum   = 0;
    for (int k = 0; k < held_n; k++) begin
      turn = waited + held_burst[k];
      wsum += waited;
      tsum += turn;
      r = '0;
      r.job_id     = ID_W'(held_id[k] + 1);
      r.job_burst  = held_burst[k];
      r.job_prio   = held_prio[k];
      r.wait_time  = WAIT_W'(waited);
      r.turnaround = WAIT_W'(turn);
      if (k + 1 == held_n) begin
        r.wait_total       = WSUM_W'(wsum);
        r.turnaround_total = TSUM_W'(tsum);
        r.end_of_run       = 1'b1;
      end
      r.overflowed = held_drop;
      sched_q.push_back(r);
      waited = turn;
    end
    held_n    = 0;
    held_drop = 1'b0;
  endfunction

  function automatic logic [BURST_W-1:0] pick_burst();
    case ($urandom_range(7))
      0, 1: return BURST_W'($urandom_range(15));
      2:    return '1;
      3:    return '0;
      default: return BURST_W'($urandom);
    endcase
  endfunction

  // Lean on a narrow range so ties are common
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    case ($urandom_range(7))
      0, 1, 2: return PRIO_W'(int'($urandom_range(6)) - 3);
      3:       return 16'sh8000;
      4:       return 16'sh7fff;
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Drive one job beat from a falling edge; return at the falling edge after acceptance
  task automatic send_job(input job_t beat, input logic typed, input res_t want);
    while ($urandom_range(99) < src_idle) begin
      job_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    job_if.valid <= 1'b1;
    job_if.data  <= beat;
    do @(posedge clk_i); while (!job_if.ready);
    take_job(beat);
    if (typed) begin
      void'(sched_q.pop_back());
      sched_q.push_back(want);
    end
    @(negedge clk_i);
  endtask

  // Hold the sender until every queued result has arrived and the block is idle
  task automatic settle();
    job_if.valid <= 1'b0;
    while (sched_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_LOWER_FIRST) low_first = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_e c);
    if (c != CFG_KEEP) begin
      settle();
      case (c)
        CFG_HIGH_FIRST: apb_write(ADDR_LOWER_FIRST, MODE_HIGH_FIRST);
        CFG_LOW_FIRST:  apb_write(ADDR_LOWER_FIRST, MODE_LOW_FIRST);
        default:        apb_write(ADDR_SPARE, MODE_HIGH_FIRST);
      endcase
      apb_read_check(ADDR_LOWER_FIRST, {31'b0, low_first});
    end
  endtask

  // Send one set of random jobs; sizes past capacity exercise the drop path
  task automatic send_set(input int size);
    job_t beat;
    for (int k = 0; k < size; k++) begin
      beat.burst     = pick_burst();
      beat.prio      = pick_prio();
      beat.final_job = (k == size - 1);
      send_job(beat, 1'b0, '0);
    end
  endtask

  // Mostly small sets, now and then a larger one; pause for a full drain at random
  task automatic run_sets(input int budget);
    int sent;
    int size;
    sent = 0;
    while (sent < budget) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
      send_set(size);
      sent += size;
      if ($urandom_range(5) == 0) settle();
    end
  endtask

  // Receiver: random backpressure, changed at the falling edge
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Compare each result beat against the oldest queued schedule entry
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (sched_q.size() == 0) begin
        $error("result beat with no schedule entry waiting");
        mismatches++;
      end else begin
        want_beat = sched_q.pop_front();
        check_field("job_id", want_beat.job_id, res_if.data.job_id);
        check_field("job_burst", want_beat.job_burst, res_if.data.job_burst);
        check_field("job_prio", want_beat.job_prio, res_if.data.job_prio);
        check_field("wait_time", want_beat.wait_time, res_if.data.wait_time);
        check_field("turnaround", want_beat.turnaround, res_if.data.turnaround);
        check_field("wait_total", want_beat.wait_total, res_if.data.wait_total);
        check_field("turnaround_total", want_beat.turnaround_total,
                    res_if.data.turnaround_total);
        check_field("overflowed", want_beat.overflowed, res_if.data.overflowed);
        check_field("end_of_run", want_beat.end_of_run, res_if.data.end_of_run);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    job_if.valid <= 1'b0;
    job_if.data  <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, with the register at its reset value first
    src_idle  = 7;
    sink_idle = 48;
    apb_read_check(ADDR_LOWER_FIRST, MODE_HIGH_FIRST);
    for (int r = 0; r < $size(PLAN); r++) begin
      apply_cfg(PLAN[r].cfg);
      send_job(PLAN[r].beat, PLAN[r].typed, PLAN[r].want);
    end

    // Larger priority first, busy sender and slow receiver; drop a job and the final job
    apply_cfg(CFG_HIGH_FIRST);
    run_sets(8);
    send_set(JOB_CAP + 2);
    settle();

    // Smaller priority first, slow sender and eager receiver
    src_idle  = 48;
    sink_idle = 7;
    apply_cfg(CFG_LOW_FIRST);
    run_sets(10);
    settle();

    // Random order mode, no idling on either side
    src_idle  = 0;
    sink_idle = 0;
    apb_write(ADDR_LOWER_FIRST, $urandom_range(1));
    apb_read_check(ADDR_LOWER_FIRST, {31'b0, low_first});
    run_sets(8);
    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && sched_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
